// ----- sv/ppfa_pkg.sv -----
// Shared constants, codes and control types of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package ppfa_pkg;

    // Store geometry
    localparam int NUM_FRAMES  = 16384;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = NUM_FRAMES / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);
    localparam int WORD_AW     = FRAME_IDX_W - BIT_W;
    localparam int CNT_W       = FRAME_IDX_W + 1;

    // Field and register widths
    localparam int ADDR_W     = 32;
    localparam int FRAME_W    = 20;
    localparam int LIMIT_W    = 15;
    localparam int PAGE_SHIFT = 12;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [ADDR_W-1:0]  PAGE_BYTES        = 32'h0000_1000;
    localparam logic [ADDR_W-1:0]  REGION_BASE_BYTES = 32'h01c0_0000;
    localparam logic [FRAME_W-1:0] BASE_FRAME_RESET  =
        FRAME_W'(REGION_BASE_BYTES / PAGE_BYTES);
    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = LIMIT_W'(NUM_FRAMES);

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic {
        REG_BASE_FRAME  = 1'b0,
        REG_FRAME_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    clr_wr;
        logic    req_load;
        logic    scan_start;
        logic    scan_rd;
        logic    set_wr;
        logic    free_rd;
        logic    clr_bit_wr;
        logic    res_load;
        t_status res_code;
        logic    res_addr_sel;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic count_zero;
        logic scan_hit;
        logic scan_end;
        logic free_ok;
        logic free_hit;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- sv/ppfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/ppfa_dp.sv -----
// Datapath: in-use bitmap store, scan pipeline, free check and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ppfa_pkg::t_dp_cmd                i_cmd,
    input  wire logic [ppfa_pkg::ADDR_W-1:0]      i_addr,
    input  wire logic [ppfa_pkg::FRAME_W-1:0]     i_base_frame,
    input  wire logic [ppfa_pkg::LIMIT_W-1:0]     i_frame_limit,
    output ppfa_pkg::t_dp_sts                     o_sts,
    output logic      [ppfa_pkg::ADDR_W-1:0]      o_page_addr,
    output ppfa_pkg::t_status                     o_status
);

    import ppfa_pkg::*;

    logic [WORD_AW-1:0]     r_rd_w;
    logic [WORD_AW-1:0]     n_rd_w;
    logic [WORD_AW-1:0]     r_chk_w;
    logic                   r_chk_vld;
    logic [FRAME_IDX_W-1:0] r_free_idx;
    logic                   r_free_ok;
    logic [ADDR_W-1:0]      r_res_addr;
    t_status                r_res_status;
    logic [ADDR_W-1:0]      r_out_addr;
    t_status                r_out_status;

    logic [CNT_W-1:0]       count;
    logic [CNT_W:0]         cnt_round;
    logic [CNT_W-BIT_W:0]   nwords;
    logic [WORD_AW-1:0]     last_w;
    logic [BIT_W-1:0]       tail;
    logic [WORD_BITS-1:0]   valid_mask;
    logic [WORD_BITS-1:0]   avail;
    logic [WORD_BITS-1:0]   lowest;
    logic [BIT_W-1:0]       bit_idx;
    logic [FRAME_W-1:0]     hit_pfn;
    logic [ADDR_W-1:0]      hit_addr;
    logic [FRAME_W-1:0]     req_off;
    logic                   req_ok;
    logic [WORD_AW-1:0]     free_word;
    logic [WORD_BITS-1:0]   free_mask;

    logic                   ram_we;
    logic [WORD_AW-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [WORD_AW-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    // Managed frame count and the last word that holds any of them
    always_comb begin
        if (int'(i_frame_limit) > NUM_FRAMES) begin
            count = CNT_W'(NUM_FRAMES);
        end else begin
            count = CNT_W'(i_frame_limit);
        end
        cnt_round = {1'b0, count} + (CNT_W + 1)'(WORD_BITS - 1);
        nwords    = cnt_round[CNT_W:BIT_W];
        last_w    = WORD_AW'(nwords - 1'b1);
        tail      = count[BIT_W-1:0];
    end

    // Scan check: free bits of the word just read, lowest one wins
    always_comb begin
        if (r_chk_w != last_w || tail == '0) begin
            valid_mask = '1;
        end else begin
            valid_mask = (WORD_BITS'(1) << tail) - WORD_BITS'(1);
        end
        avail  = ~ram_rdata & valid_mask;
        lowest = avail & (~avail + WORD_BITS'(1));
        bit_idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (lowest[b]) begin
                bit_idx = bit_idx | BIT_W'(b);
            end
        end
        hit_pfn  = i_base_frame + FRAME_W'({r_chk_w, bit_idx});
        hit_addr = {hit_pfn, {PAGE_SHIFT{1'b0}}};
    end

    // Free request: frame offset from base, wrapping in the frame number space
    always_comb begin
        req_off   = i_addr[ADDR_W-1:PAGE_SHIFT] - i_base_frame;
        req_ok    = (i_addr[PAGE_SHIFT-1:0] == '0) && (req_off < FRAME_W'(count));
        free_word = r_free_idx[FRAME_IDX_W-1:BIT_W];
        free_mask = WORD_BITS'(1) << r_free_idx[BIT_W-1:0];
    end

    always_comb begin
        n_rd_w = r_rd_w;
        if (i_cmd.clr_wr) begin
            n_rd_w = r_rd_w + 1'b1;
        end else if (i_cmd.scan_start) begin
            n_rd_w = '0;
        end else if (i_cmd.scan_rd && r_rd_w != last_w) begin
            n_rd_w = r_rd_w + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_w    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_rd_w <= n_rd_w;
            if (i_cmd.scan_start) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_chk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_chk_w <= r_rd_w;
        end
        if (i_cmd.req_load) begin
            r_free_idx <= req_off[FRAME_IDX_W-1:0];
            r_free_ok  <= req_ok;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_code;
            r_res_addr   <= i_cmd.res_addr_sel ? hit_addr : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    // Store port muxing
    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.set_wr | i_cmd.clr_bit_wr;
        ram_waddr = r_rd_w;
        ram_wdata = '0;
        if (i_cmd.set_wr) begin
            ram_waddr = r_chk_w;
            ram_wdata = ram_rdata | lowest;
        end else if (i_cmd.clr_bit_wr) begin
            ram_waddr = free_word;
            ram_wdata = ram_rdata & ~free_mask;
        end
        ram_re    = i_cmd.scan_rd | i_cmd.free_rd;
        ram_raddr = i_cmd.free_rd ? free_word : r_rd_w;
    end

    ppfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.clr_last   = (r_rd_w == WORD_AW'(NUM_WORDS - 1));
        o_sts.count_zero = (count == '0);
        o_sts.scan_hit   = r_chk_vld && (avail != '0);
        o_sts.scan_end   = r_chk_vld && (avail == '0) && (r_chk_w == last_w);
        o_sts.free_ok    = r_free_ok;
        o_sts.free_hit   = (ram_rdata & free_mask) != '0;
    end

    assign o_page_addr = r_out_addr;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

// ----- sv/ppfa_ctrl.sv -----
// Controller: sequences clearing, allocate scan, free check and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_func,
    input  wire logic              i_out_ready,
    input  wire ppfa_pkg::t_dp_sts i_sts,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output ppfa_pkg::t_dp_cmd      o_cmd
);

    import ppfa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_func'(i_func) == FUNC_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.count_zero || i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                n_state = i_sts.free_ok ? S_FREE_CHK : S_DONE;
            end
            S_FREE_CHK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.res_code = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.req_load   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.count_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_NO_FREE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    if (i_sts.scan_hit) begin
                        o_cmd.set_wr       = 1'b1;
                        o_cmd.res_load     = 1'b1;
                        o_cmd.res_code     = ST_OK;
                        o_cmd.res_addr_sel = 1'b1;
                    end else if (i_sts.scan_end) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = ST_NO_FREE;
                    end
                end
            end
            S_FREE_RD: begin
                if (i_sts.free_ok) begin
                    o_cmd.free_rd = 1'b1;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_NOT_FOUND;
                end
            end
            S_FREE_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_sts.free_hit) begin
                    o_cmd.clr_bit_wr = 1'b1;
                    o_cmd.res_code   = ST_OK;
                end else begin
                    o_cmd.res_code = ST_NOT_FOUND;
                end
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/physical_page_frame_allocator_core.sv -----
// Top level of the first-fit physical page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel (i_valid / o_ready): i_func selects allocate or free,
//   i_addr is the byte address of the frame to free (ignored on allocate).
//   Response channel (o_valid / i_ready): o_page_addr is the allocated frame
//   address (zero on free and on any failure), o_status is OK, no free frame
//   or not found.
//   APB port: register 0 at byte 0 holds the base frame number, register 1 at
//   byte 4 the number of managed frames. Write them only while the block idles.
// Throughput
//   One request at a time. A free goes from accept through a bitmap read and a
//   check state to the response, and skips both when the address is rejected.
//   An allocate reads one 32-frame bitmap word per cycle from the store's read
//   port until it finds a free bit or has checked the last managed word;
//   the next request is accepted the cycle after the response is registered.
// Reset
//   After reset a clearing pass zeroes the bitmap one word per cycle, with
//   o_ready low; APB writes are taken during that pass.
// Stall
//   The response sits in an output register: a new request is accepted while
//   it waits, and that request's result is held until the register drains.

module physical_page_frame_allocator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_func,
    input  wire logic [ppfa_pkg::ADDR_W-1:0]     i_addr,
    // response channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [ppfa_pkg::ADDR_W-1:0]     o_page_addr,
    output logic      [1:0]                      o_status,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ppfa_pkg::CFG_AW-1:0]     paddr,
    input  wire logic [ppfa_pkg::CFG_DW-1:0]     pwdata,
    output logic      [ppfa_pkg::CFG_DW-1:0]     prdata,
    output logic                                 pready
);

    import ppfa_pkg::*;

    logic [FRAME_W-1:0] r_base_frame;
    logic [LIMIT_W-1:0] r_frame_limit;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    t_status            w_status;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    // Configuration registers: write on the access phase, zero-wait
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_frame  <= BASE_FRAME_RESET;
            r_frame_limit <= FRAME_LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BASE_FRAME: begin
                    r_base_frame <= pwdata[FRAME_W-1:0];
                end
                REG_FRAME_LIMIT: begin
                    r_frame_limit <= pwdata[LIMIT_W-1:0];
                end
                default: begin
                    r_base_frame <= r_base_frame;
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb begin
        case (cfg_idx)
            REG_BASE_FRAME: begin
                prdata = CFG_DW'(r_base_frame);
            end
            REG_FRAME_LIMIT: begin
                prdata = CFG_DW'(r_frame_limit);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Sequencer: owns request/response handshakes and steps the datapath
    ppfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    // Bitmap store, first-fit search and result registers
    ppfa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_addr        (i_addr),
        .i_base_frame  (r_base_frame),
        .i_frame_limit (r_frame_limit),
        .o_sts         (w_sts),
        .o_page_addr   (o_page_addr),
        .o_status      (w_status)
    );

    assign o_status = w_status;

    // One request in flight: ready drops after a request is accepted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in flight");

    // A failed request never carries a page address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_page_addr == '0))
        else $error("failure response with nonzero page address");

    // Clearing, allocate marking and free unmarking never drive the write port in the same cycle
    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_wr, w_cmd.set_wr, w_cmd.clr_bit_wr}))
        else $error("bitmap write port driven by two sources");

    // The bitmap is only marked on a found free bit
    a_mark_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.set_wr |-> (w_sts.scan_hit && !w_sts.count_zero))
        else $error("bitmap marked without a free bit found");

endmodule

`default_nettype wire
